// ===== hdl/pcam_pkg.sv =====
package pcam_pkg;

   localparam int AddrWidth   = 32;
   localparam int PageShift   = 20;
   localparam int BucketBits  = 12;
   localparam int PoolEntries = 1024;
   localparam int SlotBits    = $clog2(PoolEntries);
   localparam int LinkBits    = SlotBits + 1;
   localparam int ValueWidth  = 32;
   localparam int Buckets     = 1 << BucketBits;

   typedef logic [LinkBits-1:0] link_type;
   typedef logic [SlotBits-1:0] slot_type;
   typedef logic [BucketBits-1:0] bucket_type;

   localparam link_type Nil = link_type'(PoolEntries);

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_WALK,
      S_DONE
   } state_type;

   // pool memory command from the controller
   typedef struct packed {
      logic     rd;
      slot_type rd_slot;
      logic     wr_link;
      slot_type wr_link_slot;
      link_type wr_link_data;
      logic     wr_entry;
      slot_type wr_entry_slot;
      logic [AddrWidth-1:0]  wr_addr;
      logic [ValueWidth-1:0] wr_value;
      link_type wr_entry_link;
   } pool_cmd_type;

   typedef struct packed {
      logic [AddrWidth-1:0]  addr;
      logic [ValueWidth-1:0] value;
      link_type link;
   } pool_rd_type;

   function automatic bucket_type bucket_of(input logic [AddrWidth-1:0] a);
      return a[PageShift +: BucketBits];
   endfunction

endpackage

// ===== hdl/pcam_head_mem.sv =====
module pcam_head_mem (
   input  logic clock,
   input  logic reset,
   input  logic rd,
   input  pcam_pkg::bucket_type rd_bucket,
   input  logic wr,
   input  pcam_pkg::bucket_type wr_bucket,
   input  pcam_pkg::link_type wr_data,
   output pcam_pkg::link_type rd_data,
   output logic clear_busy
);
   import pcam_pkg::*;

   link_type   mem [Buckets];
   logic [BucketBits:0] clr_ff, clr_in;

   assign clear_busy = !clr_ff[BucketBits];

   always_comb begin
      clr_in = clr_ff;
      if (clear_busy) clr_in = clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   // clearing pass writes the empty mark into every bucket
   always_ff @(posedge clock) begin
      if (clear_busy) mem[clr_ff[BucketBits-1:0]] <= Nil;
      else if (wr) mem[wr_bucket] <= wr_data;
      if (rd) rd_data <= mem[rd_bucket];
   end
endmodule

// ===== hdl/pcam_pool_mem.sv =====
module pcam_pool_mem (
   input  logic clock,
   input  pcam_pkg::pool_cmd_type cmd,
   output pcam_pkg::pool_rd_type rd_data
);
   import pcam_pkg::*;

   logic [AddrWidth-1:0]  addr_mem  [PoolEntries];
   logic [ValueWidth-1:0] value_mem [PoolEntries];
   link_type              link_mem  [PoolEntries];

   always_ff @(posedge clock) begin
      if (cmd.wr_entry) begin
         addr_mem[cmd.wr_entry_slot]  <= cmd.wr_addr;
         value_mem[cmd.wr_entry_slot] <= cmd.wr_value;
      end
      if (cmd.wr_entry) link_mem[cmd.wr_entry_slot] <= cmd.wr_entry_link;
      else if (cmd.wr_link) link_mem[cmd.wr_link_slot] <= cmd.wr_link_data;
      if (cmd.rd) begin
         rd_data.addr  <= addr_mem[cmd.rd_slot];
         rd_data.value <= value_mem[cmd.rd_slot];
         rd_data.link  <= link_mem[cmd.rd_slot];
      end
   end
endmodule

// ===== hdl/pcam_free_stack.sv =====
module pcam_free_stack (
   input  logic clock,
   input  logic push,
   input  pcam_pkg::link_type push_ptr,
   input  pcam_pkg::slot_type push_slot,
   input  logic rd,
   input  pcam_pkg::slot_type rd_ptr,
   output pcam_pkg::slot_type rd_slot
);
   import pcam_pkg::*;

   slot_type mem [PoolEntries];

   always_ff @(posedge clock) begin
      if (push) mem[push_ptr[SlotBits-1:0]] <= push_slot;
      if (rd) rd_slot <= mem[rd_ptr];
   end
endmodule

// ===== hdl/paged_chained_address_map.sv =====
// result: a result is registered after the bucket head read and the read
// of the first chain entry, if any; find and erase also read one further
// entry for each chain entry passed without a match, insert and the unused
// code none. throughput: one item at a time; the next item is taken once
// the last is done and its result is not held waiting on a stall.
// reset: synchronous; a clearing pass empties all 4096 bucket heads,
// during which no item is accepted. free count and used count clear.
module paged_chained_address_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_address,
   input  logic [31:0] req_alloc_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_value,
   output logic [1:0]  rsp_status
);
   import pcam_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [AddrWidth-1:0]  addr_ff, addr_in;
   logic [ValueWidth-1:0] val_ff, val_in;
   link_type  cur_ff, cur_in, prev_ff, prev_in;
   link_type  free_cnt_ff, free_cnt_in, high_ff, high_in;
   logic [LinkBits:0] steps_ff, steps_in;
   logic      out_v_ff, out_v_in;
   logic [ValueWidth-1:0] out_val_ff, out_val_in;
   status_type out_st_ff, out_st_in;
   logic      pop_ff, pop_in;

   logic      head_rd, head_wr, clear_busy;
   link_type  head_wdata, head_q;
   pool_cmd_type cmd;
   pool_rd_type  pool_q;
   logic      fs_push, fs_rd;
   slot_type  fs_q;

   pcam_head_mem u_head (
      .clock, .reset, .rd(head_rd), .rd_bucket(bucket_of(req_address)),
      .wr(head_wr), .wr_bucket(bucket_of(addr_ff)), .wr_data(head_wdata),
      .rd_data(head_q), .clear_busy
   );
   pcam_pool_mem u_pool (.clock, .cmd, .rd_data(pool_q));
   pcam_free_stack u_free (
      .clock, .push(fs_push), .push_ptr(free_cnt_ff), .push_slot(cur_ff[SlotBits-1:0]),
      .rd(fs_rd), .rd_ptr(slot_type'(free_cnt_ff - 1'b1)), .rd_slot(fs_q)
   );

   wire accept = req_valid && !req_stall;
   assign req_stall = clear_busy || state_ff != S_IDLE || (out_v_ff && rsp_stall);
   assign rsp_valid = out_v_ff;
   assign rsp_result_value = out_val_ff;
   assign rsp_status = out_st_ff;

   // pool entry under the walk matches the key
   logic hit;
   always_comb begin
      hit = pool_q.addr == addr_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_HEAD;
         S_HEAD: state_in = S_WALK;
         S_WALK: if (op_ff == OP_INSERT || op_ff == OP_NONE) state_in = S_DONE;
                 else if (cur_ff >= Nil || steps_ff >= (LinkBits+1)'(PoolEntries) || hit)
                    state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in = op_ff; addr_in = addr_ff; val_in = val_ff;
      cur_in = cur_ff; prev_in = prev_ff; steps_in = steps_ff;
      free_cnt_in = free_cnt_ff; high_in = high_ff; pop_in = pop_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_val_in = out_val_ff; out_st_in = out_st_ff;
      head_rd = accept; head_wr = 1'b0; head_wdata = Nil;
      fs_push = 1'b0; fs_rd = 1'b0;
      cmd = '0;
      cmd.wr_addr = addr_ff; cmd.wr_value = val_ff;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            op_in = op_type'(req_operation); addr_in = req_address;
            val_in = req_alloc_value; prev_in = Nil; steps_in = '0;
            pop_in = free_cnt_ff != '0 && free_cnt_ff <= Nil;
            fs_rd = 1'b1;
         end
         S_HEAD: begin
            cur_in = head_q;
            cmd.rd = head_q < Nil;
            cmd.rd_slot = head_q[SlotBits-1:0];
         end
         S_WALK: begin
            unique case (op_ff)
               OP_INSERT: begin
                  out_v_in = 1'b1; out_val_in = '0; out_st_in = ST_OK;
                  if (pop_ff) begin
                     free_cnt_in = free_cnt_ff - 1'b1;
                     cmd.wr_entry_slot = fs_q;
                  end else begin
                     cmd.wr_entry_slot = high_ff[SlotBits-1:0];
                  end
                  if (pop_ff || high_ff < Nil) begin
                     if (!pop_ff) high_in = high_ff + 1'b1;
                     cmd.wr_entry = 1'b1; cmd.wr_entry_link = cur_ff;
                     head_wr = 1'b1; head_wdata = {1'b0, cmd.wr_entry_slot};
                  end else out_st_in = ST_FULL;
               end
               OP_FIND, OP_ERASE: begin
                  if (cur_ff >= Nil || steps_ff >= (LinkBits+1)'(PoolEntries)) begin
                     out_v_in = 1'b1; out_val_in = '0; out_st_in = ST_NOT_FOUND;
                  end else if (hit) begin
                     out_v_in = 1'b1; out_st_in = ST_OK;
                     out_val_in = (op_ff == OP_FIND) ? pool_q.value : '0;
                     if (op_ff == OP_ERASE) begin
                        if (prev_ff < Nil) begin
                           cmd.wr_link = 1'b1; cmd.wr_link_slot = prev_ff[SlotBits-1:0];
                           cmd.wr_link_data = pool_q.link;
                        end else begin
                           head_wr = 1'b1; head_wdata = pool_q.link;
                        end
                        if (free_cnt_ff < Nil) begin
                           fs_push = 1'b1; free_cnt_in = free_cnt_ff + 1'b1;
                        end
                     end
                  end else begin
                     prev_in = cur_ff; cur_in = pool_q.link;
                     steps_in = steps_ff + 1'b1;
                     cmd.rd = pool_q.link < Nil;
                     cmd.rd_slot = pool_q.link[SlotBits-1:0];
                  end
               end
               default: begin
                  out_v_in = 1'b1; out_val_in = '0; out_st_in = ST_NOT_FOUND;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_v_ff <= 1'b0;
         free_cnt_ff <= '0; high_ff <= '0;
      end else begin
         state_ff <= state_in; out_v_ff <= out_v_in;
         free_cnt_ff <= free_cnt_in; high_ff <= high_in;
      end
      op_ff <= op_in; addr_ff <= addr_in; val_ff <= val_in;
      cur_ff <= cur_in; prev_ff <= prev_in; steps_ff <= steps_in;
      out_val_ff <= out_val_in; out_st_ff <= out_st_in; pop_ff <= pop_in;
   end

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !accept) else $error("item taken during clear");
   a_free_le_high: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= high_ff) else $error("free count above used count");
   a_high_bound: assert property (@(posedge clock) disable iff (reset)
      high_ff <= Nil) else $error("used count overflow");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> !(out_v_ff && !$past(out_v_ff)) ) else $error("early result");
endmodule
